[src/twd_pkg.sv]
// Shared types and constants for the trigger wheel decoder.
package twd_pkg;

    localparam int ErrW = 11;

    localparam logic [ErrW-1:0] ERR_FUTURE          = 11'h001;
    localparam logic [ErrW-1:0] ERR_PAST            = 11'h002;
    localparam logic [ErrW-1:0] ERR_MISSED          = 11'h004;
    localparam logic [ErrW-1:0] ERR_MISSED_TRIG     = 11'h008;
    localparam logic [ErrW-1:0] ERR_WHEEL_MISSED    = 11'h010;
    localparam logic [ErrW-1:0] ERR_GAINED          = 11'h020;
    localparam logic [ErrW-1:0] ERR_WHEEL_MISS_TRIG = 11'h040;
    localparam logic [ErrW-1:0] ERR_SHORT           = 11'h080;
    localparam logic [ErrW-1:0] ERR_CHANGED         = 11'h100;
    localparam logic [ErrW-1:0] ERR_WRONG_TIME      = 11'h200;
    localparam logic [ErrW-1:0] ERR_TIMER_FULL      = 11'h400;

    localparam logic [7:0] TOOTH_OFF = 8'hFF;

    localparam logic [1:0] ACT_PULSE = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    localparam logic [1:0] REG_TEETH_TOTAL   = 2'd0;
    localparam logic [1:0] REG_TEETH_MISSING = 2'd1;
    localparam logic [1:0] REG_MAX_INTERVAL  = 2'd2;
    localparam logic [1:0] REG_MAX_FUTURE    = 2'd3;

    localparam logic KIND_FIRE   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PRE,
        ST_DIV1,
        ST_DIV2,
        ST_TOOTH,
        ST_ROLL,
        ST_SCANINIT,
        ST_SCAN,
        ST_MUL,
        ST_SUM,
        ST_EMIT,
        ST_STATUS
    } state_t;

    typedef struct packed {
        logic [7:0] pfrac;
        logic [7:0] ptooth;
        logic [7:0] frac;
        logic [7:0] tooth;
    } entry_pos_t;

    typedef struct packed {
        logic [7:0]  pins;
        logic [31:0] len;
    } entry_out_t;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic        busy;
        logic [31:0] quotient;
    } div_rsp_t;

endpackage

[src/trigger_wheel_decoder_top.sv]
// Missing-tooth crank wheel decoder: sequencer, state, trigger scan and output register.
//
//  channel   | dir | handshake             | contents
//  s_*       | in  | s_tvalid / s_tready   | tuser: action; tdata: pulse, now, entry write
//  m_*       | out | m_tvalid / m_tready   | tuser: kind; tlast: last; tdata: result fields
//  cfg_*     | in  | cfg_wr_en             | cfg_addr selects register, cfg_wdata value
//
// One transaction at a time. A tooth pulse in the slow-average phase makes two passes through
// the shared 32-step divider (one when the average is zero, none in the fast-average phase),
// then one roll-over subtract per wrap of the tooth count, and, once synced, a scan over
// (tooth, entry) pairs with a multiply, sum and emit step for each fired entry.
// Reset is synchronous; no clearing pass. A stalled m_tready holds the sequencer at its
// next result.
module trigger_wheel_decoder_top #(
    parameter int NUM_TRIGGERS = 4,
    parameter int LOOKAHEAD    = 4,
    parameter int MAX_FIRES    = 8
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [47:0] pulse_time, [95:48] now_time, [97:96] entry_index, [105:98] entry_tooth,
    // [113:106] entry_fraction, [145:114] entry_pulse_length, [153:146] entry_pins
    input  logic [159:0] s_tdata,
    // [1:0] action
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [1:0] fire_index, [49:2] on_time, [97:50] off_time, [98] has_off,
    // [106:99] fire_pins, [117:107] error_flags, [125:118] tooth_position,
    // [157:126] tooth_period
    output logic [159:0] m_tdata,
    // [0] kind
    output logic         m_tuser,
    output logic         m_tlast,
    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_addr,
    input  logic [31:0]  cfg_wdata
);
    import twd_pkg::*;

    localparam int IW = (NUM_TRIGGERS > 1) ? $clog2(NUM_TRIGGERS) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(NUM_TRIGGERS - 1);
    localparam logic [9:0]    LOOK = 10'(LOOKAHEAD);
    localparam logic [5:0]    FIRE_LIM = 6'(MAX_FIRES);

    state_t state_reg, state_next;

    // configuration
    logic [7:0]  total_reg, missing_reg;
    logic [30:0] maxi_reg;
    logic [31:0] maxf_reg;

    // captured transaction
    logic [1:0]  act_reg, act_next;
    logic [47:0] pulse_reg, pulse_next, now_reg, now_next;
    logic [1:0]  widx_reg, widx_next;
    logic [7:0]  wtooth_reg, wtooth_next, wfrac_reg, wfrac_next, wpins_reg, wpins_next;
    logic [31:0] wlen_reg, wlen_next;

    // wheel state
    logic [47:0] prev_reg, prev_next;
    logic [31:0] avgi_reg, avgi_next, atp_reg, atp_next, pss_reg, pss_next;
    logic [7:0]  tc_reg, tc_next, wgc_reg, wgc_next;
    logic [ErrW-1:0] err_reg, err_next;
    entry_pos_t  pos_reg [NUM_TRIGGERS];
    entry_pos_t  pos_next [NUM_TRIGGERS];
    entry_out_t  eout_reg [NUM_TRIGGERS];
    entry_out_t  eout_next [NUM_TRIGGERS];

    // work registers
    logic [30:0] diff_reg, diff_next;
    logic [7:0]  teeth_reg, teeth_next, last_reg, last_next;
    logic [8:0]  cur_reg, cur_next;
    logic [9:0]  t_reg, t_next;
    logic [IW-1:0] i_reg, i_next;
    logic [5:0]  fires_reg, fires_next;
    logic [31:0] mula_reg, mula_next;
    logic signed [43:0] mulb_reg, mulb_next;
    logic [47:0] on_reg, on_next;

    // output register
    logic        ov_reg, ov_next;
    logic        okind_reg, okind_next, olast_reg, olast_next, ohas_reg, ohas_next;
    logic [1:0]  oidx_reg, oidx_next;
    logic [47:0] oon_reg, oon_next, ooff_reg, ooff_next;
    logic [7:0]  opins_reg, opins_next, otooth_reg, otooth_next;
    logic [ErrW-1:0] oerr_reg, oerr_next;
    logic [31:0] oper_reg, oper_next;

    div_req_t div_req;
    div_rsp_t div_rsp;

    twd_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    logic        out_free;
    logic [47:0] d48, p48, dval;
    logic        back, clamp;
    logic [31:0] pss_use;
    logic [32:0] fsum, q33;
    logic [7:0]  q8, tsum, tc_new;
    logic [34:0] slow_sum;
    entry_pos_t  cpos;
    logic        match, adv_end;
    logic signed [10:0] tdiff;
    logic signed [50:0] tt, lim;

    assign out_free = !ov_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            total_reg   <= 8'd36;
            missing_reg <= 8'd1;
            maxi_reg    <= 31'd1000000;
            maxf_reg    <= 32'd500000;
            prev_reg    <= '0;
            avgi_reg    <= '0;
            atp_reg     <= '0;
            pss_reg     <= '0;
            tc_reg      <= '0;
            wgc_reg     <= '0;
            err_reg     <= '0;
            ov_reg      <= 1'b0;
            fires_reg   <= '0;
            for (int k = 0; k < NUM_TRIGGERS; k++) begin
                pos_reg[k]  <= '{pfrac: 8'd0, ptooth: TOOTH_OFF, frac: 8'd0, tooth: TOOTH_OFF};
                eout_reg[k] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_TEETH_TOTAL:   total_reg   <= cfg_wdata[7:0];
                    REG_TEETH_MISSING: missing_reg <= cfg_wdata[7:0];
                    REG_MAX_INTERVAL:  maxi_reg    <= cfg_wdata[30:0];
                    REG_MAX_FUTURE:    maxf_reg    <= cfg_wdata;
                    default: ;
                endcase
            end
            prev_reg  <= prev_next;
            avgi_reg  <= avgi_next;
            atp_reg   <= atp_next;
            pss_reg   <= pss_next;
            tc_reg    <= tc_next;
            wgc_reg   <= wgc_next;
            err_reg   <= err_next;
            ov_reg    <= ov_next;
            fires_reg <= fires_next;
            pos_reg   <= pos_next;
            eout_reg  <= eout_next;
        end
        act_reg    <= act_next;
        pulse_reg  <= pulse_next;
        now_reg    <= now_next;
        widx_reg   <= widx_next;
        wtooth_reg <= wtooth_next;
        wfrac_reg  <= wfrac_next;
        wpins_reg  <= wpins_next;
        wlen_reg   <= wlen_next;
        diff_reg   <= diff_next;
        teeth_reg  <= teeth_next;
        last_reg   <= last_next;
        cur_reg    <= cur_next;
        t_reg      <= t_next;
        i_reg      <= i_next;
        mula_reg   <= mula_next;
        mulb_reg   <= mulb_next;
        on_reg     <= on_next;
        okind_reg  <= okind_next;
        olast_reg  <= olast_next;
        ohas_reg   <= ohas_next;
        oidx_reg   <= oidx_next;
        oon_reg    <= oon_next;
        ooff_reg   <= ooff_next;
        opins_reg  <= opins_next;
        otooth_reg <= otooth_next;
        oerr_reg   <= oerr_next;
        oper_reg   <= oper_next;
    end

    always_comb begin
        state_next  = state_reg;
        act_next    = act_reg;
        pulse_next  = pulse_reg;
        now_next    = now_reg;
        widx_next   = widx_reg;
        wtooth_next = wtooth_reg;
        wfrac_next  = wfrac_reg;
        wpins_next  = wpins_reg;
        wlen_next   = wlen_reg;
        prev_next   = prev_reg;
        avgi_next   = avgi_reg;
        atp_next    = atp_reg;
        pss_next    = pss_reg;
        tc_next     = tc_reg;
        wgc_next    = wgc_reg;
        err_next    = err_reg;
        pos_next    = pos_reg;
        eout_next   = eout_reg;
        diff_next   = diff_reg;
        teeth_next  = teeth_reg;
        last_next   = last_reg;
        cur_next    = cur_reg;
        t_next      = t_reg;
        i_next      = i_reg;
        fires_next  = fires_reg;
        mula_next   = mula_reg;
        mulb_next   = mulb_reg;
        on_next     = on_reg;
        ov_next     = ov_reg && !m_tready;
        okind_next  = okind_reg;
        olast_next  = olast_reg;
        ohas_next   = ohas_reg;
        oidx_next   = oidx_reg;
        oon_next    = oon_reg;
        ooff_next   = ooff_reg;
        opins_next  = opins_reg;
        otooth_next = otooth_reg;
        oerr_next   = oerr_reg;
        oper_next   = oper_reg;
        div_req     = '{start: 1'b0, dividend: 32'd0, divisor: 32'd1};

        d48     = pulse_reg - prev_reg;
        back    = d48[47];
        p48     = back ? (prev_reg + {16'd0, avgi_reg}) : pulse_reg;
        dval    = back ? 48'd0 : d48;
        clamp   = dval > {17'd0, maxi_reg};
        pss_use = clamp ? 32'd0 : pss_reg;
        fsum    = {1'b0, avgi_reg} + {2'b0, (clamp ? maxi_reg : dval[30:0])};
        q33     = ({1'b0, div_rsp.quotient} + 33'd1) >> 1;
        q8      = (q33 > 33'd255) ? 8'd255 : ((q33 == 33'd0) ? 8'd1 : q33[7:0]);
        slow_sum = ({avgi_reg, 3'b0} - {3'b0, avgi_reg}) + {4'b0, diff_reg};
        tsum    = last_reg + teeth_reg;
        tc_new  = tsum;
        cpos    = pos_reg[i_reg];
        match   = (cpos.tooth != TOOTH_OFF) &&
                  (({2'b0, cpos.tooth} == t_reg) ||
                   ((10'(cpos.tooth) + 10'(total_reg)) == t_reg));
        adv_end = (i_reg == LAST_IDX) && ((t_reg + 10'd1) >= (10'(cur_reg) + LOOK));
        tdiff   = $signed({1'b0, t_reg}) - $signed({2'b0, cur_reg});
        tt      = $signed({3'b0, prev_reg}) + $signed({19'b0, mula_reg})
                  + 51'(mulb_reg);
        lim     = $signed({2'b0, {1'b0, prev_reg} + {17'b0, maxf_reg}});

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    act_next    = s_tuser;
                    pulse_next  = s_tdata[47:0];
                    now_next    = s_tdata[95:48];
                    widx_next   = s_tdata[97:96];
                    wtooth_next = s_tdata[105:98];
                    wfrac_next  = s_tdata[113:106];
                    wlen_next   = s_tdata[145:114];
                    wpins_next  = s_tdata[153:146];
                    state_next  = (s_tuser == ACT_PULSE) ? ST_PRE : ST_STATUS;
                end
            end
            ST_PRE: begin
                if (back) err_next = err_next | ERR_WRONG_TIME;
                prev_next = p48;
                diff_next = clamp ? maxi_reg : dval[30:0];
                pss_next  = (pss_use == 32'hFFFFFFFF) ? pss_use : pss_use + 32'd1;
                last_next = tc_reg;
                if (pss_use < 32'd8) begin
                    avgi_next  = fsum[32:1];
                    atp_next   = fsum[32:1];
                    teeth_next = 8'd1;
                    state_next = ST_TOOTH;
                end else if (avgi_reg == 32'd0) begin
                    // zero average: tooth count saturates
                    teeth_next = 8'd255;
                    avgi_next  = {4'd0, diff_next[30:3]};
                    div_req    = '{start: 1'b1, dividend: {1'b0, diff_next},
                                   divisor: 32'd255};
                    state_next = ST_DIV2;
                end else begin
                    div_req    = '{start: 1'b1, dividend: {diff_next, 1'b0},
                                   divisor: avgi_reg};
                    state_next = ST_DIV1;
                end
            end
            ST_DIV1: begin
                if (div_rsp.done) begin
                    if (div_rsp.quotient == 32'd0) err_next = err_next | ERR_SHORT;
                    teeth_next = q8;
                    avgi_next  = slow_sum[34:3];
                    div_req    = '{start: 1'b1, dividend: {1'b0, diff_reg},
                                   divisor: {24'd0, q8}};
                    state_next = ST_DIV2;
                end
            end
            ST_DIV2: begin
                if (div_rsp.done) begin
                    atp_next = 32'((({atp_reg, 3'b0} - {3'b0, atp_reg})
                               + {3'b0, div_rsp.quotient}) >> 3);
                    state_next = ST_TOOTH;
                end
            end
            ST_TOOTH: begin
                if (teeth_reg > missing_reg) begin
                    if ({1'b0, teeth_reg} != ({1'b0, missing_reg} + 9'd1))
                        err_next = err_next | ERR_MISSED_TRIG;
                    if (tsum == total_reg) begin
                        wgc_next = '0;
                        tc_new   = '0;
                    end else begin
                        err_next = err_next |
                                   ((tsum < total_reg) ? ERR_WHEEL_MISSED : ERR_GAINED);
                        wgc_next = wgc_reg + 8'd1;
                        if (wgc_next > 8'd1) begin
                            // second wrong gap in a row: realign
                            wgc_next = '0;
                            tc_new   = '0;
                            err_next = err_next | ERR_CHANGED;
                        end
                    end
                end else if (teeth_reg != 8'd1) begin
                    err_next = err_next | ERR_MISSED;
                end
                tc_next = tc_new;
                if (total_reg != 8'd0 && tc_new >= total_reg) begin
                    err_next   = err_next | ERR_WHEEL_MISS_TRIG;
                    state_next = ST_ROLL;
                end else begin
                    state_next = ST_SCANINIT;
                end
            end
            ST_ROLL: begin
                if (tc_reg >= total_reg) tc_next = tc_reg - total_reg;
                else state_next = ST_SCANINIT;
            end
            ST_SCANINIT: begin
                cur_next   = (tc_reg < last_reg) ? (9'(tc_reg) + 9'(total_reg)) : 9'(tc_reg);
                t_next     = 10'(last_reg) + LOOK;
                i_next     = '0;
                fires_next = '0;
                if (pss_reg > {24'd0, total_reg} && t_next < (10'(cur_next) + LOOK))
                    state_next = ST_SCAN;
                else
                    state_next = ST_STATUS;
            end
            ST_SCAN: begin
                if (match) begin
                    state_next = ST_MUL;
                end else if (adv_end) begin
                    state_next = ST_STATUS;
                end else if (i_reg == LAST_IDX) begin
                    i_next = '0;
                    t_next = t_reg + 10'd1;
                end else begin
                    i_next = i_reg + IW'(1);
                end
            end
            ST_MUL: begin
                mula_next  = 32'(({32'd0, cpos.frac} * {8'd0, atp_reg}) >> 8);
                mulb_next  = 44'(tdiff) * 44'($signed({1'b0, atp_reg}));
                state_next = ST_SUM;
            end
            ST_SUM: begin
                if (tt > lim) begin
                    on_next  = lim[47:0];
                    err_next = err_next | ERR_FUTURE;
                    if (lim < $signed({3'b0, now_reg})) err_next = err_next | ERR_PAST;
                end else begin
                    on_next = tt[47:0];
                    if (tt < $signed({3'b0, now_reg})) err_next = err_next | ERR_PAST;
                end
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (fires_reg >= FIRE_LIM || out_free) begin
                    if (fires_reg < FIRE_LIM) begin
                        fires_next  = fires_reg + 6'd1;
                        ov_next     = 1'b1;
                        okind_next  = KIND_FIRE;
                        olast_next  = 1'b0;
                        oidx_next   = 2'(i_reg);
                        oon_next    = on_reg;
                        ohas_next   = eout_reg[i_reg].len != 32'd0;
                        ooff_next   = ohas_next ? (on_reg + {16'd0, eout_reg[i_reg].len})
                                                : 48'd0;
                        opins_next  = eout_reg[i_reg].pins;
                        oerr_next   = err_reg;
                        otooth_next = tc_reg;
                        oper_next   = atp_reg;
                    end else begin
                        err_next = err_next | ERR_TIMER_FULL;
                    end
                    pos_next[i_reg].tooth = cpos.ptooth;
                    pos_next[i_reg].frac  = cpos.pfrac;
                    if (adv_end) begin
                        state_next = ST_STATUS;
                    end else begin
                        state_next = ST_SCAN;
                        if (i_reg == LAST_IDX) begin
                            i_next = '0;
                            t_next = t_reg + 10'd1;
                        end else begin
                            i_next = i_reg + IW'(1);
                        end
                    end
                end
            end
            ST_STATUS: begin
                if (out_free) begin
                    ov_next     = 1'b1;
                    okind_next  = KIND_STATUS;
                    olast_next  = 1'b1;
                    oidx_next   = '0;
                    oon_next    = '0;
                    ooff_next   = '0;
                    ohas_next   = 1'b0;
                    opins_next  = '0;
                    oerr_next   = err_reg;
                    otooth_next = tc_reg;
                    oper_next   = atp_reg;
                    if (act_reg == ACT_CLEAR) err_next = '0;
                    if (act_reg == ACT_WRITE) begin
                        for (int k = 0; k < NUM_TRIGGERS; k++) begin
                            if (5'(k) == {3'd0, widx_reg}) begin
                                if (pos_reg[k].tooth == TOOTH_OFF) begin
                                    pos_next[k].tooth = wtooth_reg;
                                    pos_next[k].frac  = wfrac_reg;
                                end
                                pos_next[k].ptooth = wtooth_reg;
                                pos_next[k].pfrac  = wfrac_reg;
                                eout_next[k] = '{pins: wpins_reg, len: wlen_reg};
                            end
                        end
                    end
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign m_tvalid = ov_reg;
    assign m_tuser  = okind_reg;
    assign m_tlast  = olast_reg;
    assign m_tdata  = {2'b0, oper_reg, otooth_reg, oerr_reg, opins_reg, ohas_reg,
                       ooff_reg, oon_reg, oidx_reg};

    // status items and only they close a transaction
    a_last_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == m_tuser))
        else $error("tlast does not match status kind");

    a_status_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata[98:0] == 99'd0))
        else $error("status item carries fire payload");

    a_fire_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        fires_reg <= FIRE_LIM)
        else $error("fire count beyond limit");

    a_rolled: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCANINIT && total_reg != 8'd0) |-> (tc_reg < total_reg))
        else $error("tooth position not rolled over");

    a_div_owner: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.busy |-> (state_reg == ST_DIV1 || state_reg == ST_DIV2))
        else $error("divider busy outside divide states");

endmodule

[src/twd_div.sv]
// Radix-2 restoring divider, 32-bit, one quotient bit per cycle.
module twd_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  twd_pkg::div_req_t req,
    output twd_pkg::div_rsp_t rsp
);
    import twd_pkg::*;

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] dsr_reg, dsr_next;
    logic [32:0] trial;
    logic        ge;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    always_comb begin
        trial     = {rem_reg, quo_reg[31]};
        ge        = trial >= {1'b0, dsr_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (busy_reg) begin
            rem_next = ge ? 32'(trial - {1'b0, dsr_reg}) : trial[31:0];
            quo_next = {quo_reg[30:0], ge};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end else if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = req.dividend;
            dsr_next  = req.divisor;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.busy     = busy_reg;
    assign rsp.quotient = quo_reg;

endmodule
